@@ hdl/assert_macros.svh @@
// assertion macros used by the checker in pfl_checker.sv
// no dependencies; include guard below
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PFL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define PFL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication that is also checked across reset
`define PFL_ASSERT_NEXT_ANY(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/pfl_pkg.sv @@
// shared types and constants for the peak follower with lowpass
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pfl_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int AGE_BITS      = 8;
  localparam int FRAC_BITS     = 16;
  localparam int COEF_BITS     = 16;
  localparam int TIMEOUT_BITS  = 8;
  localparam int ACC_BITS      = SAMPLE_BITS + FRAC_BITS;
  localparam int MUL_A_BITS    = COEF_BITS + 1;
  localparam int MUL_B_BITS    = ACC_BITS;
  localparam int PROD_BITS     = MUL_A_BITS + MUL_B_BITS;
  localparam int SUM_BITS      = PROD_BITS + 1;
  localparam int AGE_CMP_BITS  = (AGE_BITS > TIMEOUT_BITS) ? AGE_BITS : TIMEOUT_BITS;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [AGE_BITS-1:0]   AGE_MAX   = {AGE_BITS{1'b1}};
  localparam logic [MUL_A_BITS-1:0] ONE_Q16   = MUL_A_BITS'(1) << FRAC_BITS;
  localparam logic [SUM_BITS-1:0]   ROUND_HALF = SUM_BITS'(1) << (FRAC_BITS - 1);

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_FOLLOW_RATIO = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SMOOTH_COEFF = 2'd2;

  // register reset values
  localparam logic [COEF_BITS-1:0]    FOLLOW_RATIO_RST = 16'd58982;
  localparam logic [TIMEOUT_BITS-1:0] HOLD_TIMEOUT_RST = 8'd40;
  localparam logic [COEF_BITS-1:0]    SMOOTH_COEFF_RST = 16'd65470;

  // operand selection for the shared multiplier
  typedef enum logic [1:0] {
    MUL_RATIO = 2'd0,   // held peak times follow ratio
    MUL_KACC  = 2'd1,   // coefficient times filter state
    MUL_TGT   = 2'd2    // one minus coefficient times held peak
  } mul_sel_t;

  typedef struct packed {
    logic     load_sample;  // capture the accepted sample
    mul_sel_t mul_sel;
    logic     load_prod;    // register the multiplier output
    logic     decide;       // refresh / timeout decision on the held peak
    logic     finish;       // write filter state and result registers
  } pfl_cmd_t;

endpackage

`default_nettype wire

@@ hdl/pfl_ctrl.sv @@
// sequencing state machine for the peak follower
// depends on pfl_pkg
`timescale 1ns / 1ps
`default_nettype none

module pfl_ctrl import pfl_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  output pfl_cmd_t      cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RATIO = 4'b0010,
    ST_KACC  = 4'b0100,
    ST_TGT   = 4'b1000
  } state_t;

  state_t st_r, st_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid && (st_r == ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    st_nxt          = st_r;
    cmd.load_sample = accept;
    cmd.mul_sel     = MUL_RATIO;
    cmd.load_prod   = 1'b0;
    cmd.decide      = 1'b0;
    cmd.finish      = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (accept) st_nxt = ST_RATIO;
      end
      ST_RATIO: begin
        cmd.mul_sel   = MUL_RATIO;
        cmd.load_prod = 1'b1;
        st_nxt        = ST_KACC;
      end
      ST_KACC: begin
        cmd.mul_sel   = MUL_KACC;
        cmd.load_prod = 1'b1;
        cmd.decide    = 1'b1;
        st_nxt        = ST_TGT;
      end
      ST_TGT: begin
        cmd.mul_sel = MUL_TGT;
        // wait here while the previous result is still unclaimed
        if (out_free) begin
          cmd.finish = 1'b1;
          st_nxt     = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (st_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ hdl/pfl_datapath.sv @@
// registers, shared multiplier and result registers of the peak follower
// depends on pfl_pkg
`timescale 1ns / 1ps
`default_nettype none

module pfl_datapath import pfl_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire pfl_cmd_t                 cmd,
  input  wire logic [SAMPLE_BITS-1:0]   in_sample,
  input  wire logic                     cfg_wr_en,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output logic [SAMPLE_BITS-1:0]        out_peak_value,
  output logic [SAMPLE_BITS-1:0]        out_smoothed_value
);

  logic [COEF_BITS-1:0]    follow_ratio_r;
  logic [TIMEOUT_BITS-1:0] hold_timeout_r;
  logic [COEF_BITS-1:0]    smooth_coeff_r;

  logic [SAMPLE_BITS-1:0]  sample_r;
  logic [SAMPLE_BITS-1:0]  peak_r, peak_nxt;
  logic [AGE_BITS-1:0]     age_r, age_nxt, age_inc;
  logic                    started_r, started_nxt;
  logic                    first_r, first_nxt;
  logic [ACC_BITS-1:0]     acc_r, acc_nxt;
  logic [PROD_BITS-1:0]    prod_r;
  logic [SAMPLE_BITS-1:0]  out_peak_r;
  logic [SAMPLE_BITS-1:0]  out_smooth_r;

  logic [MUL_A_BITS-1:0]   mul_a;
  logic [MUL_B_BITS-1:0]   mul_b;
  logic [PROD_BITS-1:0]    prod_c;
  logic [PROD_BITS-1:0]    lhs;
  logic [SUM_BITS-1:0]     sum;
  logic                    refresh;
  logic                    timed_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      follow_ratio_r <= FOLLOW_RATIO_RST;
      hold_timeout_r <= HOLD_TIMEOUT_RST;
      smooth_coeff_r <= SMOOTH_COEFF_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FOLLOW_RATIO: follow_ratio_r <= cfg_wdata[COEF_BITS-1:0];
        REG_HOLD_TIMEOUT: hold_timeout_r <= cfg_wdata[TIMEOUT_BITS-1:0];
        REG_SMOOTH_COEFF: smooth_coeff_r <= cfg_wdata[COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier operand selection
  always_comb begin
    case (cmd.mul_sel)
      MUL_RATIO: begin
        mul_a = MUL_A_BITS'(follow_ratio_r);
        mul_b = MUL_B_BITS'(peak_r);
      end
      MUL_KACC: begin
        mul_a = MUL_A_BITS'(smooth_coeff_r);
        mul_b = acc_r;
      end
      MUL_TGT: begin
        mul_a = ONE_Q16 - MUL_A_BITS'(smooth_coeff_r);
        mul_b = MUL_B_BITS'(peak_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_c = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

  // refresh test against the registered peak times ratio
  assign lhs       = PROD_BITS'(sample_r) << FRAC_BITS;
  assign refresh   = (lhs >= prod_r);
  assign age_inc   = (age_r != AGE_MAX) ? age_r + AGE_BITS'(1) : age_r;
  assign timed_out = AGE_CMP_BITS'(age_inc) > AGE_CMP_BITS'(hold_timeout_r);

  always_comb begin
    peak_nxt    = peak_r;
    age_nxt     = age_r;
    started_nxt = started_r;
    first_nxt   = first_r;
    if (cmd.decide) begin
      first_nxt = !started_r;
      if (!started_r) begin
        peak_nxt    = sample_r;
        age_nxt     = '0;
        started_nxt = 1'b1;
      end else if (refresh) begin
        peak_nxt = sample_r;
        age_nxt  = '0;
      end else begin
        age_nxt = age_inc;
        if (timed_out) peak_nxt = '0;
      end
    end
  end

  // k*acc is in prod_r, (1-k)*peak comes from the multiplier now
  assign sum = SUM_BITS'(prod_r) + (SUM_BITS'(prod_c) << FRAC_BITS) + ROUND_HALF;

  always_comb begin
    if (first_r) acc_nxt = ACC_BITS'(peak_r) << FRAC_BITS;
    else acc_nxt = sum[ACC_BITS+FRAC_BITS-1:FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r    <= '0;
      age_r     <= '0;
      started_r <= 1'b0;
      first_r   <= 1'b0;
      acc_r     <= '0;
    end else begin
      peak_r    <= peak_nxt;
      age_r     <= age_nxt;
      started_r <= started_nxt;
      first_r   <= first_nxt;
      if (cmd.finish) acc_r <= acc_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.load_sample) sample_r <= in_sample;
    if (cmd.load_prod) prod_r <= prod_c;
    if (cmd.finish) begin
      out_peak_r   <= peak_r;
      out_smooth_r <= acc_nxt[ACC_BITS-1:FRAC_BITS];
    end
  end

  assign out_peak_value     = out_peak_r;
  assign out_smoothed_value = out_smooth_r;

endmodule

`default_nettype wire

@@ hdl/peak_follower_lowpass.sv @@
// top level of the peak follower with hold timeout and lowpass
// depends on pfl_pkg, pfl_ctrl and pfl_datapath
//
// usage
// - input channel: in_valid / in_stall with in_sample; a transaction takes
//   place on a rising edge with in_valid high and in_stall low
// - result channel: out_valid / out_stall with out_peak_value and
//   out_smoothed_value; one result transaction per input transaction
// - configuration: cfg_wr_en, cfg_index, cfg_wdata; write only while idle
//   (index 0 follow ratio, 1 hold timeout, 2 smoothing coefficient)
// - result: each sample steps through the ratio, k*acc and target states;
//   out_valid rises once the target state finds the result channel free
// - the single shared multiplier is used three times per sample (ratio,
//   k*y, (1-k)*peak); a new sample is taken only after these are done
// - in_stall is low only in the idle state; a new sample is taken while
//   the previous result still waits in the output register
// - receiver stall: the result stays in the output register; a following
//   sample runs up to its last step and waits there
// - reset: synchronous active low; registers return to their defaults,
//   the peak, age and filter state clear and the next sample loads them
`timescale 1ns / 1ps
`default_nettype none

module peak_follower_lowpass import pfl_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [SAMPLE_BITS-1:0]   in_sample,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [SAMPLE_BITS-1:0]        out_peak_value,
  output logic [SAMPLE_BITS-1:0]        out_smoothed_value,
  input  wire logic                     cfg_wr_en,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  // command bundle from the sequencer to the datapath
  pfl_cmd_t cmd;

  pfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // peak tracking, filter state and result registers
  pfl_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_sample          (in_sample),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_peak_value     (out_peak_value),
    .out_smoothed_value (out_smoothed_value)
  );

endmodule

`default_nettype wire

@@ hdl/pfl_checker.sv @@
// port-level checks for the peak follower, bound to the top level
// depends on pfl_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pfl_checker import pfl_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_stall,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire logic [SAMPLE_BITS-1:0] out_peak_value,
  input wire logic [SAMPLE_BITS-1:0] out_smoothed_value
);

  // stalled result holds
  `PFL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_peak_value) && $stable(out_smoothed_value))

  // one sample in flight at a time
  `PFL_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && !in_stall, in_stall)

  // after reset the block is idle and empty
  `PFL_ASSERT_NEXT_ANY(a_reset_idle, clk, !rst_n, !in_stall && !out_valid)

  // a result follows an input transaction once the output is free
  `PFL_ASSERT_NEXT(a_result_due, clk, rst_n, $past(in_valid && !in_stall, 3) && $past(rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1) && (!out_valid || !out_stall), out_valid)

  // the block is idle again once a result has been produced
  `PFL_ASSERT_SAME(a_idle_after_result, clk, rst_n, $rose(out_valid), !in_stall)

endmodule

bind peak_follower_lowpass pfl_checker u_pfl_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_peak_value     (out_peak_value),
  .out_smoothed_value (out_smoothed_value)
);

`default_nettype wire

@@ dv/tb_peak_follower_lowpass.sv @@
// self-checking testbench for peak_follower_lowpass: directed and random samples,
// an internal envelope tracker predicts the held peak and smoothed value
// depends on pfl_pkg and the peak_follower_lowpass rtl
`timescale 1ns / 1ps

module tb_peak_follower_lowpass;
  import pfl_pkg::*;

  // quiet cycles after the last result before registers change or the run ends
  localparam int SETTLE_CYCLES  = 8;
  // cycles with no transaction on either channel before the run is abandoned
  localparam int WATCHDOG_LIMIT = 400;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 100;
  localparam int MAX_REPORTS    = 10;

  // one result transaction as seen on the output ports
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] peak;
    logic [SAMPLE_BITS-1:0] smooth;
  } envelope_t;

  // ways of picking the next random sample
  typedef enum logic [2:0] {
    SHAPE_NEAR,    // around the refresh threshold of the held peak
    SHAPE_ATTACK,  // at or above the held peak
    SHAPE_QUIET,   // well below the peak, lets the hold time run out
    SHAPE_ANY,     // full range, every bit
    SHAPE_EDGE     // zero or full scale
  } shape_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [SAMPLE_BITS-1:0]   in_sample = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [SAMPLE_BITS-1:0]   out_peak_value;
  logic [SAMPLE_BITS-1:0]   out_smoothed_value;
  logic                     cfg_wr_en = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = REG_FOLLOW_RATIO;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  // tracker copy of the register settings
  logic [15:0] cur_ratio   = FOLLOW_RATIO_RST;
  logic [7:0]  cur_timeout = HOLD_TIMEOUT_RST;
  logic [15:0] cur_coeff   = SMOOTH_COEFF_RST;

  // tracker copy of the envelope state
  logic [SAMPLE_BITS-1:0] trk_peak   = '0;
  logic [AGE_BITS-1:0]    trk_age    = '0;
  logic                   trk_primed = 1'b0;
  logic [ACC_BITS-1:0]    trk_acc    = '0;

  // predicted results, oldest first
  envelope_t envelope_q[$];

  // random idling on both channels, cleared for the closing stretch
  bit idle_on = 1'b0;

  int err_count     = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int settings_used = 0;
  int quiet_cycles  = 0;

  peak_follower_lowpass DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_peak_value     (out_peak_value),
    .out_smoothed_value (out_smoothed_value),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // ---------------------------------------------------------------------------
  // envelope tracker: advances the held peak, age and lowpass by one sample
  // ---------------------------------------------------------------------------
  function automatic envelope_t track_sample(input logic [SAMPLE_BITS-1:0] s);
    logic [63:0] scaled_sample;
    logic [63:0] peak_share;
    logic [63:0] blend;
    envelope_t   r;
    // age counts up before the test and sticks at its ceiling
    if (trk_age != AGE_MAX) trk_age = trk_age + 1'b1;
    if (!trk_primed) begin
      // very first sample loads everything, no blending
      trk_peak   = s;
      trk_age    = '0;
      trk_primed = 1'b1;
      trk_acc    = {s, {FRAC_BITS{1'b0}}};
    end else begin
      scaled_sample = 64'(s) << FRAC_BITS;
      peak_share    = 64'(trk_peak) * 64'(cur_ratio);
      if (scaled_sample >= peak_share) begin
        trk_peak = s;
        trk_age  = '0;
      end else if (trk_age > cur_timeout) begin
        trk_peak = '0;
      end
      // y = k*y + (1-k)*peak, rounded half up
      blend = 64'(cur_coeff) * 64'(trk_acc)
            + (64'd65536 - 64'(cur_coeff)) * (64'(trk_peak) << FRAC_BITS)
            + 64'd32768;
      trk_acc = blend[FRAC_BITS +: ACC_BITS];
    end
    r.peak   = trk_peak;
    r.smooth = trk_acc[ACC_BITS-1 -: SAMPLE_BITS];
    return r;
  endfunction

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // input side: one sample transaction, with an optional gap in front
  // ---------------------------------------------------------------------------
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    // accepted at this edge, tracker moves on
    envelope_q.push_back(track_sample(s));
    items_sent++;
  endtask

  // wait until every predicted result has come back and the block has gone quiet
  task automatic drain;
    in_valid <= 1'b0;
    while (envelope_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes all three registers on consecutive edges, only called while idle
  task automatic apply_regs(input logic [15:0] ratio, input logic [7:0] tmo,
                            input logic [15:0] coeff);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_FOLLOW_RATIO;
    cfg_wdata <= CFG_DATA_BITS'(ratio);
    @(posedge clk);
    cfg_index <= REG_HOLD_TIMEOUT;
    cfg_wdata <= CFG_DATA_BITS'(tmo);
    @(posedge clk);
    cfg_index <= REG_SMOOTH_COEFF;
    cfg_wdata <= CFG_DATA_BITS'(coeff);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_ratio   = ratio;
    cur_timeout = tmo;
    cur_coeff   = coeff;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset settings: first sample loads peak and filter, then samples either
  // side of the 0.9 refresh threshold, equal samples and the field extremes
  task automatic test_threshold_defaults;
    logic [SAMPLE_BITS-1:0] seq[8];
    seq = '{16'hFFFF, 16'h0000, 16'd58981, 16'd58982, 16'd58982, 16'd53085,
            16'hFFFF, 16'h0001};
    foreach (seq[i]) send_sample(seq[i]);
    drain();
  endtask

  // ratio zero: every sample refreshes, including zero after a larger sample
  task automatic test_ratio_zero;
    logic [SAMPLE_BITS-1:0] seq[4];
    seq = '{16'd100, 16'd5, 16'h0000, 16'hFFFF};
    apply_regs(16'h0000, 8'd10, 16'd32768);
    foreach (seq[i]) send_sample(seq[i]);
    drain();
  endtask

  // full ratio with zero timeout and zero coefficient: a miss drops the peak
  // at once, a zero peak is reloaded by anything, the lowpass tracks exactly
  task automatic test_timeout_zero;
    logic [SAMPLE_BITS-1:0] seq[6];
    seq = '{16'd40000, 16'd39999, 16'd7, 16'd7, 16'd6, 16'hFFFF};
    apply_regs(16'hFFFF, 8'd0, 16'h0000);
    foreach (seq[i]) send_sample(seq[i]);
    drain();
  endtask

  // full retention coefficient: the smoothed value barely moves
  task automatic test_coeff_full;
    logic [SAMPLE_BITS-1:0] seq[6];
    seq = '{16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h1234};
    apply_regs(FOLLOW_RATIO_RST, 8'd3, 16'hFFFF);
    foreach (seq[i]) send_sample(seq[i]);
    drain();
  endtask

  // age saturation: with a timeout at the age ceiling the peak is held for
  // good; dropping the timeout by one then lets the next miss clear it
  task automatic test_age_saturation;
    idle_on = 1'b1;
    apply_regs(16'hFFFF, 8'd255, 16'($urandom_range(0, 65535)));
    send_sample(16'hFFFF);
    // only full scale passes a full ratio against a full-scale peak
    repeat (270) send_sample(16'($urandom_range(0, 65534)));
    drain();
    apply_regs(16'hFFFF, 8'd254, cur_coeff);
    send_sample(16'd1000);
    send_sample(16'd999);
    send_sample(16'hFFFF);
    drain();
  endtask

  // random settings per phase and shaped sample streams
  task automatic test_random_envelopes;
    logic [15:0]            ratio;
    logic [7:0]             tmo;
    logic [15:0]            coeff;
    logic [63:0]            thr;
    logic [SAMPLE_BITS-1:0] s;
    shape_t                 shape;
    int                     pick;
    int                     v;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      pick = $urandom_range(0, 9);
      ratio = (pick == 0) ? 16'h0000 :
              (pick == 1) ? 16'hFFFF :
              (pick <= 3) ? 16'($urandom_range(0, 65535)) :
                            16'($urandom_range(32768, 64000));
      pick = $urandom_range(0, 9);
      tmo = (pick == 0) ? 8'd0 :
            (pick == 1) ? 8'd255 :
            (pick == 2) ? 8'($urandom_range(0, 255)) :
                          8'($urandom_range(1, 30));
      pick = $urandom_range(0, 9);
      coeff = (pick == 0) ? 16'h0000 :
              (pick == 1) ? 16'hFFFF :
              (pick <= 4) ? 16'($urandom_range(0, 65535)) :
                            16'($urandom_range(60000, 65535));
      apply_regs(ratio, tmo, coeff);
      // the closing phase runs without any idling
      idle_on = (ph != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick  = $urandom_range(0, 99);
        shape = (pick < 40) ? SHAPE_NEAR :
                (pick < 58) ? SHAPE_ATTACK :
                (pick < 78) ? SHAPE_QUIET :
                (pick < 95) ? SHAPE_ANY : SHAPE_EDGE;
        case (shape)
          SHAPE_NEAR: begin
            // smallest sample that still refreshes, plus a little jitter
            thr = (64'(trk_peak) * 64'(cur_ratio) + 64'd65535) >> FRAC_BITS;
            v = int'(thr) + int'($urandom_range(0, 6)) - 3;
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
            s = 16'(v);
          end
          SHAPE_ATTACK: s = 16'($urandom_range(int'(trk_peak), 65535));
          SHAPE_QUIET:  s = 16'($urandom_range(0, int'(trk_peak >> 2)));
          SHAPE_ANY:    s = 16'($urandom_range(0, 65535));
          default:      s = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        endcase
        send_sample(s);
      end
      drain();
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall bursts, then the comparison
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : stall_gen
    int stall_left;
    if (!rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_check
    envelope_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (envelope_q.size() == 0) begin
        flag_error($sformatf("result with nothing pending: peak %0d smooth %0d",
                             out_peak_value, out_smoothed_value));
      end else begin
        want = envelope_q.pop_front();
        if (out_peak_value !== want.peak || out_smoothed_value !== want.smooth) begin
          flag_error($sformatf("result %0d: peak exp %0d got %0d, smooth exp %0d got %0d",
                               results_seen, want.peak, out_peak_value,
                               want.smooth, out_smoothed_value));
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence of tests
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_threshold_defaults();
    test_ratio_zero();
    test_timeout_zero();
    test_coeff_full();
    test_age_saturation();
    test_random_envelopes();
    drain();
    if (envelope_q.size() != 0) flag_error("predicted results left over");
    $display("run covered %0d samples and %0d results under %0d register settings",
             items_sent, results_seen, settings_used + 1);
    $display("including age saturation, hold expiry, threshold edges and idle bursts");
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches in total", err_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
